FILE: hdl/dsfrm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dual sample FIFO mixer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.

package dsfrm_pkg;

   // Phase accumulator, unsigned fixed point with 16 fraction bits
   localparam int STEP_W  = 18;
   localparam int PHASE_W = 19;
   localparam int FRAC_W  = 16;
   localparam logic [PHASE_W-1:0] PHASE_ONE  = 19'd65536;
   localparam logic [STEP_W-1:0]  STEP_RESET = 18'd44739;

   // Scaling and mixing
   localparam int PROD_W     = 23;
   localparam int MIX_W      = 18;
   localparam int SHIFT_FULL = 8;
   localparam int SHIFT_HALF = 9;
   localparam logic signed [15:0]      SCALE_MUL = 16'sd22932;
   localparam logic signed [MIX_W-1:0] MIX_LIMIT = 18'sd32760;

   // Bits of sound_control
   localparam int CTL_FULL_A  = 2;
   localparam int CTL_FULL_B  = 3;
   localparam int CTL_A_RIGHT = 8;
   localparam int CTL_A_LEFT  = 9;
   localparam int CTL_B_RIGHT = 12;
   localparam int CTL_B_LEFT  = 13;

   // Request codes on req_type
   localparam logic [2:0] REQ_WRITE_A = 3'd0;
   localparam logic [2:0] REQ_WRITE_B = 3'd1;
   localparam logic [2:0] REQ_RENDER  = 3'd2;
   localparam logic [2:0] REQ_CLEAR_A = 3'd3;
   localparam logic [2:0] REQ_CLEAR_B = 3'd4;

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOUND_CONTROL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_STEP     = 2'd2;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [2:0] {
      OP_PUSH_A,
      OP_PUSH_B,
      OP_RENDER,
      OP_CLEAR_A,
      OP_CLEAR_B,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [31:0]        word;
      logic signed [15:0] base_left;
      logic signed [15:0] base_right;
   } cmd_type;

   typedef struct packed {
      logic [15:0]       sound_control;
      logic              master_enable;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic clear;
      logic advance;
      logic latch;
   } chan_ctl_type;

endpackage

FILE: hdl/dual_sample_fifo_resample_mixer_unit.sv
`timescale 1ns / 1ps
// Top level of the dual sample FIFO mixer: control registers, front, back and two channels.
// Depends on dsfrm_pkg, dsfrm_front, dsfrm_chan and dsfrm_back.
//
//   Channel   Handshake             Payload
//   -------   -------------------   ----------------------------------------------
//   request   start / busy          req_type, req_word, req_base_left, req_base_right
//   response  rsp_valid (strobe)    rsp_out_left, rsp_out_right, rsp_level_a, rsp_level_b
//   csr       csr_valid / csr_ready csr_index, csr_wdata
//
// Sequence: a write transaction moves through the back end one byte per cycle through the
//   single write port of the channel store; a render with the master enable set runs phase
//   advance with store read, held sample update, multiply, then mix and clamp; reset,
//   unused codes and renders with the master enable clear end in the cycle they are taken.
// The result strobe comes in the cycle after the transaction's last back-end cycle.
// A two-entry command queue lets the requester run ahead; busy rises while it is full.
// Reset (synchronous) empties both FIFOs, sets both phases to 1.0 and loads register defaults.
// The result receiver cannot stall; each strobe lasts exactly one cycle.

module dual_sample_fifo_resample_mixer_unit #(
   parameter int FIFO_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request transactions
   input  logic                                start,
   output logic                                busy,
   input  logic [2:0]                          req_type,
   input  logic [31:0]                         req_word,
   input  logic signed [15:0]                  req_base_left,
   input  logic signed [15:0]                  req_base_right,
   // result transactions
   output logic                                rsp_valid,
   output logic signed [15:0]                  rsp_out_left,
   output logic signed [15:0]                  rsp_out_right,
   output logic [5:0]                          rsp_level_a,
   output logic [5:0]                          rsp_level_b,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dsfrm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata
);

   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

   // control registers
   logic [15:0]                    sound_control_ff, sound_control_in;
   logic                           master_enable_ff, master_enable_in;
   logic [dsfrm_pkg::STEP_W-1:0]   rate_step_ff, rate_step_in;
   dsfrm_pkg::cfg_type             cfg;

   // front to back
   logic                           cmd_valid;
   logic                           cmd_ready;
   dsfrm_pkg::cmd_type             cmd;

   // back to channels
   dsfrm_pkg::chan_ctl_type        ctl_a, ctl_b;
   logic [7:0]                     push_byte;
   logic [FILL_W-1:0]              fill_a, fill_b;
   logic signed [7:0]              held_a, held_b;

   // writes are always taken; an index beyond the list is dropped
   assign csr_ready = 1'b1;

   always_comb begin
      sound_control_in = sound_control_ff;
      master_enable_in = master_enable_ff;
      rate_step_in     = rate_step_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dsfrm_pkg::CSR_SOUND_CONTROL: sound_control_in = csr_wdata[15:0];
            dsfrm_pkg::CSR_MASTER_ENABLE: master_enable_in = csr_wdata[0];
            dsfrm_pkg::CSR_RATE_STEP:     rate_step_in     = csr_wdata[dsfrm_pkg::STEP_W-1:0];
            default: begin
               sound_control_in = sound_control_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_control_ff <= '0;
         master_enable_ff <= 1'b0;
         rate_step_ff     <= dsfrm_pkg::STEP_RESET;
      end else begin
         sound_control_ff <= sound_control_in;
         master_enable_ff <= master_enable_in;
         rate_step_ff     <= rate_step_in;
      end
   end

   always_comb begin
      cfg.sound_control = sound_control_ff;
      cfg.master_enable = master_enable_ff;
   end

   // decode and queue requests
   dsfrm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_word       (req_word),
      .req_base_left  (req_base_left),
      .req_base_right (req_base_right),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_ready      (cmd_ready)
   );

   // carry out one command at a time
   dsfrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .cfg       (cfg),
      .held_a    (held_a),
      .held_b    (held_b),
      .ctl_a     (ctl_a),
      .ctl_b     (ctl_b),
      .push_byte (push_byte),
      .done      (rsp_valid),
      .out_left  (rsp_out_left),
      .out_right (rsp_out_right)
   );

   // sample channels A and B
   dsfrm_chan #(.FIFO_DEPTH(FIFO_DEPTH)) u_chan_a (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_a),
      .push_byte (push_byte),
      .step      (rate_step_ff),
      .fill      (fill_a),
      .held      (held_a)
   );

   dsfrm_chan #(.FIFO_DEPTH(FIFO_DEPTH)) u_chan_b (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_b),
      .push_byte (push_byte),
      .step      (rate_step_ff),
      .fill      (fill_b),
      .held      (held_b)
   );

   // fill counts only move at the end of a back-end cycle, so during the strobe they
   // already show the state after the finished transaction; report the low six bits
   assign rsp_level_a = 6'(fill_a);
   assign rsp_level_b = 6'(fill_b);

endmodule

FILE: hdl/dsfrm_front.sv
`timescale 1ns / 1ps
// Front end: takes request transactions, decodes them into commands and queues them.
// Depends on dsfrm_pkg.

module dsfrm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_type,
   input  logic [31:0]          req_word,
   input  logic signed [15:0]   req_base_left,
   input  logic signed [15:0]   req_base_right,
   output logic                 cmd_valid,
   output dsfrm_pkg::cmd_type   cmd,
   input  logic                 cmd_ready
);

   dsfrm_pkg::cmd_type queue_ff [dsfrm_pkg::QUEUE_DEPTH];
   dsfrm_pkg::cmd_type entry;
   logic [dsfrm_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [dsfrm_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic accept;
   logic pop;

   assign busy      = (count_ff == dsfrm_pkg::QCNT_W'(dsfrm_pkg::QUEUE_DEPTH));
   assign accept    = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = queue_ff[rd_ff];

   // classify the request
   always_comb begin
      entry.word       = req_word;
      entry.base_left  = req_base_left;
      entry.base_right = req_base_right;
      unique case (req_type)
         dsfrm_pkg::REQ_WRITE_A: entry.op = dsfrm_pkg::OP_PUSH_A;
         dsfrm_pkg::REQ_WRITE_B: entry.op = dsfrm_pkg::OP_PUSH_B;
         dsfrm_pkg::REQ_RENDER:  entry.op = dsfrm_pkg::OP_RENDER;
         dsfrm_pkg::REQ_CLEAR_A: entry.op = dsfrm_pkg::OP_CLEAR_A;
         dsfrm_pkg::REQ_CLEAR_B: entry.op = dsfrm_pkg::OP_CLEAR_B;
         default:                entry.op = dsfrm_pkg::OP_NOP;
      endcase
   end

   always_comb begin
      wr_in    = accept ? wr_ff + dsfrm_pkg::QPTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + dsfrm_pkg::QPTR_W'(1) : rd_ff;
      count_in = count_ff + dsfrm_pkg::QCNT_W'(accept) - dsfrm_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= '0;
         rd_ff    <= '0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

endmodule

FILE: hdl/dsfrm_chan.sv
`timescale 1ns / 1ps
// One sample channel: byte store, pointers, fill count, phase accumulator and held sample.
// Depends on dsfrm_pkg; instantiated twice by the top level.

module dsfrm_chan #(
   parameter int FIFO_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dsfrm_pkg::chan_ctl_type           ctl,
   input  logic [7:0]                        push_byte,
   input  logic [dsfrm_pkg::STEP_W-1:0]      step,
   output logic [$clog2(FIFO_DEPTH + 1)-1:0] fill,
   output logic signed [7:0]                 held
);

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
   localparam int PW1    = PTR_W + 1;
   localparam logic [PW1-1:0]    DEPTH_P = PW1'(FIFO_DEPTH);
   localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(FIFO_DEPTH);
   localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(FIFO_DEPTH - 1);

   logic [7:0] store_ff [FIFO_DEPTH];
   logic [7:0] rdata_ff;

   logic [PTR_W-1:0] rd_ff, rd_in, wr_ff, wr_in, raddr;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [dsfrm_pkg::PHASE_W-1:0] phase_ff, phase_in, phase_sum;
   logic signed [7:0] held_ff, held_in;
   logic upd_ff, upd_in, zero_ff, zero_in;
   logic [2:0] n_pops, n_take, n_back;
   logic short;
   logic we;
   logic [PW1-1:0] rd_sum, ra_sum;

   assign fill = fill_ff;
   assign held = held_ff;

   always_comb begin
      phase_sum = phase_ff + dsfrm_pkg::PHASE_W'(step);
      n_pops    = (step != '0) ? phase_sum[dsfrm_pkg::PHASE_W-1:dsfrm_pkg::FRAC_W] : 3'd0;
      short     = fill_ff < FILL_W'(n_pops);
      // pop what is there when the phase passes more units than are held
      n_take    = short ? 3'(fill_ff) : n_pops;
      n_back    = (n_pops != 3'd0) ? n_pops - 3'd1 : 3'd0;
      rd_sum    = {1'b0, rd_ff} + PW1'(n_take);
      ra_sum    = {1'b0, rd_ff} + PW1'(n_back);
      if (rd_sum >= DEPTH_P) begin
         rd_sum = rd_sum - DEPTH_P;
      end
      if (ra_sum >= DEPTH_P) begin
         ra_sum = ra_sum - DEPTH_P;
      end
      // only the last sample popped is kept
      raddr = ra_sum[PTR_W-1:0];
      we    = ctl.push && (fill_ff < DEPTH_F);
   end

   always_comb begin
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      fill_in  = fill_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      upd_in   = upd_ff;
      zero_in  = zero_ff;
      priority if (ctl.clear) begin
         rd_in    = '0;
         wr_in    = '0;
         fill_in  = '0;
         phase_in = dsfrm_pkg::PHASE_ONE;
         held_in  = '0;
         upd_in   = 1'b0;
      end else if (ctl.push) begin
         if (we) begin
            wr_in   = (wr_ff == LAST_P) ? '0 : wr_ff + PTR_W'(1);
            fill_in = fill_ff + FILL_W'(1);
         end
      end else if (ctl.advance) begin
         if (step != '0) begin
            phase_in = {3'b000, phase_sum[dsfrm_pkg::FRAC_W-1:0]};
         end
         rd_in   = rd_sum[PTR_W-1:0];
         fill_in = fill_ff - FILL_W'(n_take);
         upd_in  = (n_pops != 3'd0);
         zero_in = short;
      end else if (ctl.latch) begin
         if (upd_ff) begin
            held_in = zero_ff ? 8'sd0 : $signed(rdata_ff);
         end
         upd_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[wr_ff] <= push_byte;
      end
      rdata_ff <= store_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         fill_ff  <= '0;
         phase_ff <= dsfrm_pkg::PHASE_ONE;
         held_ff  <= '0;
         upd_ff   <= 1'b0;
         zero_ff  <= 1'b0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         upd_ff   <= upd_in;
         zero_ff  <= zero_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_F)
      else $error("channel fill count beyond depth");

   a_phase_wrap: assert property (@(posedge clock) disable iff (reset)
      (ctl.advance && !ctl.clear && step != '0) |=> (phase_ff < dsfrm_pkg::PHASE_ONE))
      else $error("phase not below one after advance");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.push && !ctl.clear && fill_ff < DEPTH_F) |=>
         (fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("push into a non-full channel lost a byte");

endmodule

FILE: hdl/dsfrm_back.sv
`timescale 1ns / 1ps
// Back end: sequences each queued command over the channels, scales and mixes renders.
// Depends on dsfrm_pkg; drives the channel controls and the result strobe.

module dsfrm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  dsfrm_pkg::cmd_type       cmd,
   output logic                     cmd_ready,
   input  dsfrm_pkg::cfg_type       cfg,
   input  logic signed [7:0]        held_a,
   input  logic signed [7:0]        held_b,
   output dsfrm_pkg::chan_ctl_type  ctl_a,
   output dsfrm_pkg::chan_ctl_type  ctl_b,
   output logic [7:0]               push_byte,
   output logic                     done,
   output logic signed [15:0]       out_left,
   output logic signed [15:0]       out_right
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PUSH  = 5'b00010,
      S_HOLD  = 5'b00100,
      S_SCALE = 5'b01000,
      S_MIX   = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;
   dsfrm_pkg::cmd_type cmd_ff;
   logic [1:0] byte_ff, byte_in, byte_sel;
   logic [31:0] src_word;
   logic done_ff, done_in;
   logic signed [15:0] out_left_ff, out_left_in, out_right_ff, out_right_in;
   logic signed [dsfrm_pkg::PROD_W-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic signed [dsfrm_pkg::MIX_W-1:0] da, db, sum_l, sum_r;
   logic take;
   logic push_a_now, push_b_now;

   function automatic logic signed [15:0] clamp_mix(input logic signed [dsfrm_pkg::MIX_W-1:0] v);
      logic signed [dsfrm_pkg::MIX_W-1:0] r;
      r = v;
      if (v > dsfrm_pkg::MIX_LIMIT) begin
         r = dsfrm_pkg::MIX_LIMIT;
      end else if (v < -dsfrm_pkg::MIX_LIMIT) begin
         r = -dsfrm_pkg::MIX_LIMIT;
      end
      return 16'(r);
   endfunction

   assign cmd_ready = (state_ff == S_IDLE);
   assign take      = cmd_valid && cmd_ready;
   assign done      = done_ff;
   assign out_left  = out_left_ff;
   assign out_right = out_right_ff;

   // byte lane: low byte on the take cycle, the rest from the latched word
   always_comb begin
      src_word   = take ? cmd.word : cmd_ff.word;
      byte_sel   = take ? 2'd0 : byte_ff;
      push_byte  = 8'(src_word >> {byte_sel, 3'b000});
      push_a_now = (take && cmd.op == dsfrm_pkg::OP_PUSH_A) ||
                   (state_ff == S_PUSH && cmd_ff.op == dsfrm_pkg::OP_PUSH_A);
      push_b_now = (take && cmd.op == dsfrm_pkg::OP_PUSH_B) ||
                   (state_ff == S_PUSH && cmd_ff.op == dsfrm_pkg::OP_PUSH_B);
   end

   always_comb begin
      ctl_a.push    = push_a_now;
      ctl_a.clear   = take && cmd.op == dsfrm_pkg::OP_CLEAR_A;
      ctl_a.advance = take && cmd.op == dsfrm_pkg::OP_RENDER && cfg.master_enable;
      ctl_a.latch   = (state_ff == S_HOLD);
      ctl_b.push    = push_b_now;
      ctl_b.clear   = take && cmd.op == dsfrm_pkg::OP_CLEAR_B;
      ctl_b.advance = take && cmd.op == dsfrm_pkg::OP_RENDER && cfg.master_enable;
      ctl_b.latch   = (state_ff == S_HOLD);
   end

   // scale, route and sum
   always_comb begin
      da = cfg.sound_control[dsfrm_pkg::CTL_FULL_A] ?
           dsfrm_pkg::MIX_W'(prod_a_ff >>> dsfrm_pkg::SHIFT_FULL) :
           dsfrm_pkg::MIX_W'(prod_a_ff >>> dsfrm_pkg::SHIFT_HALF);
      db = cfg.sound_control[dsfrm_pkg::CTL_FULL_B] ?
           dsfrm_pkg::MIX_W'(prod_b_ff >>> dsfrm_pkg::SHIFT_FULL) :
           dsfrm_pkg::MIX_W'(prod_b_ff >>> dsfrm_pkg::SHIFT_HALF);
      sum_l = dsfrm_pkg::MIX_W'(cmd_ff.base_left);
      sum_r = dsfrm_pkg::MIX_W'(cmd_ff.base_right);
      if (cfg.sound_control[dsfrm_pkg::CTL_A_LEFT]) begin
         sum_l = sum_l + da;
      end
      if (cfg.sound_control[dsfrm_pkg::CTL_A_RIGHT]) begin
         sum_r = sum_r + da;
      end
      if (cfg.sound_control[dsfrm_pkg::CTL_B_LEFT]) begin
         sum_l = sum_l + db;
      end
      if (cfg.sound_control[dsfrm_pkg::CTL_B_RIGHT]) begin
         sum_r = sum_r + db;
      end
   end

   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      done_in      = 1'b0;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               unique case (cmd.op)
                  dsfrm_pkg::OP_PUSH_A, dsfrm_pkg::OP_PUSH_B: begin
                     state_in = S_PUSH;
                     byte_in  = 2'd1;
                  end
                  dsfrm_pkg::OP_RENDER: begin
                     if (cfg.master_enable) begin
                        state_in = S_HOLD;
                     end else begin
                        done_in      = 1'b1;
                        out_left_in  = cmd.base_left;
                        out_right_in = cmd.base_right;
                     end
                  end
                  default: begin
                     done_in      = 1'b1;
                     out_left_in  = '0;
                     out_right_in = '0;
                  end
               endcase
            end
         end
         S_PUSH: begin
            byte_in = byte_ff + 2'd1;
            if (byte_ff == 2'd3) begin
               state_in     = S_IDLE;
               done_in      = 1'b1;
               out_left_in  = '0;
               out_right_in = '0;
            end
         end
         S_HOLD: begin
            state_in = S_SCALE;
         end
         S_SCALE: begin
            prod_a_in = dsfrm_pkg::PROD_W'(held_a) * dsfrm_pkg::PROD_W'(dsfrm_pkg::SCALE_MUL);
            prod_b_in = dsfrm_pkg::PROD_W'(held_b) * dsfrm_pkg::PROD_W'(dsfrm_pkg::SCALE_MUL);
            state_in  = S_MIX;
         end
         S_MIX: begin
            out_left_in  = clamp_mix(sum_l);
            out_right_in = clamp_mix(sum_r);
            done_in      = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd;
      end
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         byte_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         byte_ff  <= byte_in;
         done_ff  <= done_in;
      end
   end

   a_long_done: assert property (@(posedge clock) disable iff (reset)
      (take && (cmd.op == dsfrm_pkg::OP_PUSH_A || cmd.op == dsfrm_pkg::OP_PUSH_B ||
                (cmd.op == dsfrm_pkg::OP_RENDER && cfg.master_enable))) |-> ##4 done_ff)
      else $error("write or render did not finish in four cycles");

   a_short_done: assert property (@(posedge clock) disable iff (reset)
      (take && (cmd.op == dsfrm_pkg::OP_CLEAR_A || cmd.op == dsfrm_pkg::OP_CLEAR_B ||
                cmd.op == dsfrm_pkg::OP_NOP ||
                (cmd.op == dsfrm_pkg::OP_RENDER && !cfg.master_enable))) |=> done_ff)
      else $error("single-cycle command did not finish");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while a command is still in progress");

endmodule
